// File: hw/rtl/mcavg_pkg.sv
package mcavg_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CH_W     = 4;
  localparam int VREF_W   = 13;
  localparam int OHM_W    = 20;
  localparam int PIN_W    = 13;
  localparam int MEAS_W   = 16;

  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_NUM_CHANNELS   = 10;
  localparam int DEF_SETS_PER_BLOCK = 8;

  localparam logic [VREF_W-1:0] VREF_RESET   = VREF_W'(3300);
  localparam logic [OHM_W-1:0]  TOP_RESET    = OHM_W'(10000);
  localparam logic [OHM_W-1:0]  BOTTOM_RESET = OHM_W'(33000);

  // Shared divider: numerator wide enough for pin * (r1 + r2), divisor for r2
  localparam int DIV_NUM_W = PIN_W + OHM_W + 1;
  localparam int DIV_DEN_W = OHM_W;

  localparam logic [DIV_DEN_W-1:0] ADC_FULL_SCALE = DIV_DEN_W'(4095);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VREF   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_BOTTOM = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic            acc;
    logic            clr;
    logic [CH_W-1:0] addr;
  } sum_cmd_t;

endpackage

// File: hw/rtl/mcavg_div.sv
module mcavg_div #(
  parameter int NUM_W = mcavg_pkg::DIV_NUM_W,
  parameter int DEN_W = mcavg_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: hw/rtl/mcavg_sums.sv
module mcavg_sums #(
  parameter int NUM_CHANNELS = mcavg_pkg::DEF_NUM_CHANNELS,
  parameter int SUM_W        = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcavg_pkg::sum_cmd_t           cmd,
  input  logic [mcavg_pkg::SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]              sum
);
  import mcavg_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [SUM_W-1:0] sums_r [NUM_CHANNELS];
  logic [IDX_W-1:0] idx;

  assign idx = cmd.addr[IDX_W-1:0];
  assign sum = sums_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sums_r[i] <= '0;
      end
    end else if (cmd.clr) begin
      sums_r[idx] <= '0;
    end else if (cmd.acc) begin
      sums_r[idx] <= sums_r[idx] + SUM_W'(sample);
    end
  end

endmodule

// File: hw/rtl/multichannel_adc_averager_unit.sv
// Per-channel oversampling averager for a round-robin ADC scan. Samples are
// taken one per cycle while idle (channel 0 first after reset) and summed per
// channel. The sample that completes SETS_PER_BLOCK scans starts the report: for
// each channel in order the block emits channel, truncated average, pin voltage
// (avg*vref/4095) and divider-corrected voltage pin*(r1+r2)/r2 (0 if r2 is 0,
// saturated at 65535), with last_of_block on the final channel, clearing each
// channel's sum once its average is taken. All three divisions share one
// restoring divider (the third is skipped when r2 is 0), and each channel waits
// on out_ready; no sample is taken during a report.
module multichannel_adc_averager_unit #(
  parameter int NUM_CHANNELS   = mcavg_pkg::DEF_NUM_CHANNELS,
  parameter int SETS_PER_BLOCK = mcavg_pkg::DEF_SETS_PER_BLOCK
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             cfg_wr_en,
  input  logic [mcavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcavg_pkg::CFG_DATA_W-1:0] cfg_wdata,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mcavg_pkg::SAMPLE_W-1:0]   in_sample_value,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mcavg_pkg::CH_W-1:0]       out_channel_index,
  output logic [mcavg_pkg::SAMPLE_W-1:0]   out_average_raw,
  output logic [mcavg_pkg::PIN_W-1:0]      out_pin_millivolts,
  output logic [mcavg_pkg::MEAS_W-1:0]     out_measured_millivolts,
  output logic                             out_last_of_block
);
  import mcavg_pkg::*;

  localparam int SETS_LOG = (SETS_PER_BLOCK > 1) ? $clog2(SETS_PER_BLOCK) : 0;
  localparam int SCAN_W   = (SETS_PER_BLOCK > 1) ? $clog2(SETS_PER_BLOCK) : 1;
  localparam int SUM_W    = SAMPLE_W + SETS_LOG;

  localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(NUM_CHANNELS - 1);
  localparam logic [SCAN_W-1:0] LAST_SCAN = SCAN_W'(SETS_PER_BLOCK - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    S_AVG_W,
    S_PIN,
    S_PIN_W,
    S_MUL,
    S_MEAS,
    S_MEAS_W,
    S_OUT
  } state_t;

  state_t                state_r;
  logic [CH_W-1:0]       pos_r;
  logic [SCAN_W-1:0]     scans_r;
  logic [CH_W-1:0]       ch_r;
  logic [SAMPLE_W-1:0]   avg_r;
  logic [PIN_W-1:0]      pin_r;
  logic [DIV_NUM_W-1:0]  prod_r;
  logic [MEAS_W-1:0]     meas_r;

  logic [VREF_W-1:0]     vref_r;
  logic [OHM_W-1:0]      top_r;
  logic [OHM_W-1:0]      bottom_r;

  logic                  in_acc;
  logic                  out_acc;
  logic [OHM_W:0]        ohm_sum;

  sum_cmd_t              sum_cmd;
  logic [SUM_W-1:0]      sum;

  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  div_quo;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_acc  = out_valid && out_ready;
  assign ohm_sum  = {1'b0, top_r} + {1'b0, bottom_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r   <= VREF_RESET;
      top_r    <= TOP_RESET;
      bottom_r <= BOTTOM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_VREF:   vref_r   <= cfg_wdata[VREF_W-1:0];
        CFG_TOP:    top_r    <= cfg_wdata[OHM_W-1:0];
        CFG_BOTTOM: bottom_r <= cfg_wdata[OHM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    sum_cmd.acc  = in_acc;
    sum_cmd.clr  = (state_r == S_AVG_W) && div_done;
    sum_cmd.addr = (state_r == S_IDLE) ? pos_r : ch_r;
  end

  mcavg_sums #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SUM_W        (SUM_W)
  ) u_sums (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (sum_cmd),
    .sample (in_sample_value),
    .sum    (sum)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_NUM_W'(sum);
    div_den   = DIV_DEN_W'(SETS_PER_BLOCK);
    unique case (state_r)
      S_AVG: begin
        div_start = 1'b1;
      end
      S_PIN: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(avg_r) * DIV_NUM_W'(vref_r);
        div_den   = ADC_FULL_SCALE;
      end
      S_MEAS: begin
        div_start = (bottom_r != '0);
        div_num   = prod_r;
        div_den   = bottom_r;
      end
      default: ;
    endcase
  end

  mcavg_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      scans_r <= '0;
      ch_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (pos_r == LAST_CH) begin
              pos_r <= '0;
              if (scans_r == LAST_SCAN) begin
                scans_r <= '0;
                ch_r    <= '0;
                state_r <= S_AVG;
              end else begin
                scans_r <= scans_r + 1'b1;
              end
            end else begin
              pos_r <= pos_r + 1'b1;
            end
          end
        end
        S_AVG: state_r <= S_AVG_W;
        S_AVG_W: begin
          if (div_done) begin
            avg_r   <= div_quo[SAMPLE_W-1:0];
            state_r <= S_PIN;
          end
        end
        S_PIN: state_r <= S_PIN_W;
        S_PIN_W: begin
          if (div_done) begin
            pin_r   <= div_quo[PIN_W-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= DIV_NUM_W'(pin_r) * DIV_NUM_W'(ohm_sum);
          state_r <= S_MEAS;
        end
        S_MEAS: begin
          if (bottom_r == '0) begin
            meas_r  <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_MEAS_W;
          end
        end
        S_MEAS_W: begin
          if (div_done) begin
            meas_r  <= (|div_quo[DIV_NUM_W-1:MEAS_W]) ? '1 : div_quo[MEAS_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (ch_r == LAST_CH) begin
              state_r <= S_IDLE;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_AVG;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_channel_index       = ch_r;
  assign out_average_raw         = avg_r;
  assign out_pin_millivolts      = pin_r;
  assign out_measured_millivolts = meas_r;
  assign out_last_of_block       = (ch_r == LAST_CH);

endmodule

// File: tb/tb.sv
module tb;
  import mcavg_pkg::*;

  localparam int NCH           = DEF_NUM_CHANNELS;
  localparam int SETS          = DEF_SETS_PER_BLOCK;
  localparam int SAMPLES_BLOCK = NCH * SETS;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 600;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] avg;
    logic [PIN_W-1:0]    pin;
    logic [MEAS_W-1:0]   meas;
    logic                last;
  } channel_report_t;

  // Tracks per-channel sums and predicts the report emitted at each block end
  class block_average_tracker;
    logic [VREF_W-1:0] vref;
    logic [OHM_W-1:0]  r_top;
    logic [OHM_W-1:0]  r_bottom;
    int unsigned       scan_pos;
    int unsigned       scans;
    int unsigned       sums[NCH];
    channel_report_t   expected_reports[$];
    int unsigned       mismatches;
    int unsigned       reports_ok;

    function new();
      vref       = VREF_RESET;
      r_top      = TOP_RESET;
      r_bottom   = BOTTOM_RESET;
      scan_pos   = 0;
      scans      = 0;
      mismatches = 0;
      reports_ok = 0;
      foreach (sums[c]) sums[c] = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VREF:   vref = data[VREF_W-1:0];
        CFG_TOP:    r_top = data[OHM_W-1:0];
        CFG_BOTTOM: r_bottom = data[OHM_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s);
      channel_report_t  r;
      longint unsigned  avg;
      longint unsigned  pin;
      longint unsigned  meas;
      sums[scan_pos] += s;
      scan_pos++;
      if (scan_pos < NCH) return;
      scan_pos = 0;
      scans++;
      if (scans < SETS) return;
      scans = 0;
      for (int c = 0; c < NCH; c++) begin
        avg = sums[c] / SETS;
        pin = (avg * vref) / ADC_FULL_SCALE;
        if (r_bottom == 0) begin
          meas = 0;
        end else begin
          meas = (pin * (longint'(r_top) + longint'(r_bottom))) / r_bottom;
          if (meas > 65535) meas = 65535;
        end
        r.ch   = c[CH_W-1:0];
        r.avg  = avg[SAMPLE_W-1:0];
        r.pin  = pin[PIN_W-1:0];
        r.meas = meas[MEAS_W-1:0];
        r.last = (c == NCH - 1);
        expected_reports.push_back(r);
        sums[c] = 0;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void compare_report(channel_report_t got);
      channel_report_t want;
      int unsigned     before_cnt;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual channel %0d avg %0d",
                 $time, got.ch, got.avg);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      before_cnt = mismatches;
      check_field("channel_index", want.ch, got.ch);
      check_field("average_raw", want.avg, got.avg);
      check_field("pin_millivolts", want.pin, got.pin);
      check_field("measured_millivolts", want.meas, got.meas);
      check_field("last_of_block", want.last, got.last);
      if (mismatches == before_cnt) reports_ok++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [CH_W-1:0]       out_channel_index;
  logic [SAMPLE_W-1:0]   out_average_raw;
  logic [PIN_W-1:0]      out_pin_millivolts;
  logic [MEAS_W-1:0]     out_measured_millivolts;
  logic                  out_last_of_block;

  block_average_tracker tracker;
  int unsigned          burst_left;
  int unsigned          samples_sent;
  int unsigned          cfg_writes;
  int unsigned          reports_seen;
  bit                   hold_armed;

  multichannel_adc_averager_unit i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_sample_value         (in_sample_value),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_channel_index       (out_channel_index),
    .out_average_raw         (out_average_raw),
    .out_pin_millivolts      (out_pin_millivolts),
    .out_measured_millivolts (out_measured_millivolts),
    .out_last_of_block       (out_last_of_block)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    tracker.set_register(idx, data);
    cfg_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One transaction; in_valid stays high across a burst
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    samples_sent++;
    tracker.take_sample(value);
  endtask

  // Full block of scans; each channel gets a value style for the whole block
  task automatic send_block(input int unsigned lead);
    logic [SAMPLE_W-1:0] directed[20];
    int unsigned         style[NCH];
    logic [SAMPLE_W-1:0] v;
    directed = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800, 12'hFFE, 12'h7FF,
                 12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h0F0, 12'hF0F, 12'h3C3, 12'hC3C,
                 12'h002, 12'hFFD, 12'h400, 12'hBFF};
    foreach (style[c]) style[c] = $urandom_range(0, 5);
    for (int i = 0; i < SAMPLES_BLOCK; i++) begin
      if (i < lead) begin
        v = directed[i];
      end else begin
        case (style[i % NCH])
          0:       v = '0;
          1:       v = '1;
          2:       v = SAMPLE_W'($urandom_range(4088, 4095));
          3:       v = SAMPLE_W'($urandom_range(0, 7));
          default: v = SAMPLE_W'($urandom_range(0, 4095));
        endcase
      end
      send_sample(v);
    end
  endtask

  // Sender pauses until every report is in, then lets the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: own stall pattern plus one long hold-off during a report
  initial begin
    channel_report_t got;
    int unsigned     hold_left;
    int unsigned     stretch_left;
    bit              ready_now;
    hold_left    = 0;
    stretch_left = 0;
    ready_now    = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.ch   = out_channel_index;
        got.avg  = out_average_raw;
        got.pin  = out_pin_millivolts;
        got.meas = out_measured_millivolts;
        got.last = out_last_of_block;
        tracker.compare_report(got);
        reports_seen++;
      end
      if (hold_armed && out_valid) begin
        hold_armed = 1'b0;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          ready_now = !ready_now;
          if (ready_now)
            stretch_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
          else
            stretch_left = $urandom_range(1, 10);
        end
        stretch_left--;
        out_ready <= ready_now;
      end
    end
  end

  initial begin
    tracker      = new();
    burst_left   = 0;
    samples_sent = 0;
    cfg_writes   = 0;
    reports_seen = 0;
    hold_armed   = 1'b0;
    in_valid        <= 1'b0;
    in_sample_value <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, field extremes up front
    send_block(20);
    settle();

    // saturated divider output
    cfg_write(CFG_VREF, 20'd5000);
    cfg_write(CFG_TOP, 20'd1000000);
    cfg_write(CFG_BOTTOM, 20'd1);
    send_block(0);
    settle();

    // zero bottom resistor, smallest reference
    cfg_write(CFG_VREF, 20'd1);
    cfg_write(CFG_TOP, 20'd0);
    cfg_write(CFG_BOTTOM, 20'd0);
    send_block(0);
    settle();

    // oversized reference write truncates to 13 bits; spare index is ignored
    cfg_write(CFG_VREF, 20'hFFFFF);
    cfg_write(CFG_BOTTOM, 20'd1000000);
    cfg_write(CFG_SPARE_IDX, 20'hFFFFF);
    send_block(0);
    settle();

    // random settings, two blocks back to back with a long output hold-off
    cfg_write(CFG_VREF, CFG_DATA_W'($urandom_range(1, 5000)));
    cfg_write(CFG_TOP, CFG_DATA_W'($urandom_range(0, 1000000)));
    cfg_write(CFG_BOTTOM, CFG_DATA_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 200)
                                                                  : $urandom_range(0, 1000000)));
    hold_armed = 1'b1;
    send_block(0);
    send_block(0);
    settle();

    $display("Covered %0d samples, %0d channel reports (%0d clean), %0d register writes.",
             samples_sent, reports_seen, tracker.reports_ok, cfg_writes);
    $display("Settings ran from reset values through saturation, zero divisor, %s",
             "truncated reference and random values.");
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/mcavg_pkg.sv
hw/rtl/mcavg_div.sv
hw/rtl/mcavg_sums.sv
hw/rtl/multichannel_adc_averager_unit.sv
tb/tb.sv
